// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define BRS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BRS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/brs_pkg.sv =====
package brs_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int BLOCK_SIZE   = 32;
   localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int OFS_W        = $clog2(BLOCK_SIZE);
   localparam int BLK_W        = ADDR_W - OFS_W;
   localparam int CNT_W        = OFS_W + 1;
   localparam int IDX_W        = 11;
   localparam int DELTA_W      = 32;
   localparam int VAL_W        = 64;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] ACTIVE_RESET = 11'd1024;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUM = 1'b1
   } op_type;

   typedef enum logic {
      STS_DONE    = 1'b0,
      STS_INVALID = 1'b1
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_START,
      BK_WALK,
      BK_MUL,
      BK_ACC,
      BK_INNER,
      BK_DONE
   } bk_state_type;

   // one classified operation, zero-based positions
   typedef struct packed {
      op_type                     op;
      logic                       bad;
      logic [ADDR_W-1:0]          lo;
      logic [ADDR_W-1:0]          hi;
      logic signed [DELTA_W-1:0]  delta;
   } cmd_type;

   // queue occupancy seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/brs_intf.sv =====
interface brs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  opcode;
   logic [brs_pkg::IDX_W-1:0]             left_index;
   logic [brs_pkg::IDX_W-1:0]             right_index;
   logic signed [brs_pkg::DELTA_W-1:0]    delta;
   modport source (output valid, opcode, left_index, right_index, delta, input ready);
   modport sink (input valid, opcode, left_index, right_index, delta, output ready);
endinterface

interface brs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [brs_pkg::VAL_W-1:0]      range_total;
   logic                                  status;
   modport source (output valid, range_total, status, input ready);
   modport sink (input valid, range_total, status, output ready);
endinterface

interface brs_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [brs_pkg::IDX_W-1:0]             data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/block_range_add_range_sum.sv =====
// channel  dir  handshake       word
// req      in   valid/ready     opcode, left_index, right_index, delta
// rsp      out  valid/ready     range_total, status
// csr      in   valid/ready     data (active_length)
//
// after reset the element memory is cleared one entry a cycle, all 1024 entries, req.ready low
// an operation pops its command, sets up, walks the elements of its partial end blocks
// through the element memory, multiplies and folds each partial block into its block sum
// or the total, handles every inner block, then registers the result; an invalid range skips to the result
// a two-deep command queue lets req accept while the back end works, and a result
// register holds a stalled rsp word while the next operation starts
module block_range_add_range_sum (
   input  logic         clock,
   input  logic         reset,
   brs_req_if.sink      req,
   brs_rsp_if.source    rsp,
   brs_csr_if.sink      csr
);

   logic [brs_pkg::IDX_W-1:0] active_ff;
   logic                      push;
   logic                      pop;
   logic                      clearing;
   brs_pkg::cmd_type          push_cmd;
   brs_pkg::cmd_type          head;
   brs_pkg::q_stat_type       q_stat;

   // active length register
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= brs_pkg::ACTIVE_RESET;
      end else if (csr.valid) begin
         active_ff <= csr.data;
      end
   end

   brs_front u_front (
      .req           (req),
      .active_length (active_ff),
      .clearing      (clearing),
      .q_stat        (q_stat),
      .push          (push),
      .cmd           (push_cmd)
   );

   brs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   brs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .pop      (pop),
      .clearing (clearing),
      .rsp      (rsp)
   );

endmodule

// ===== rtl/brs_front.sv =====
module brs_front (
   brs_req_if.sink                    req,
   input  logic [brs_pkg::IDX_W-1:0]  active_length,
   input  logic                       clearing,
   input  brs_pkg::q_stat_type        q_stat,
   output logic                       push,
   output brs_pkg::cmd_type           cmd
);

   logic [brs_pkg::IDX_W-1:0] l_m1;
   logic [brs_pkg::IDX_W-1:0] r_m1;
   logic                      bad;

   // take a word when the queue has room and memory is initialized
   assign req.ready = !q_stat.full && !clearing;
   assign push      = req.valid && req.ready;

   // range check
   assign bad = (req.left_index == '0) ||
                (req.left_index > req.right_index) ||
                (req.right_index > active_length) ||
                (req.right_index > brs_pkg::IDX_W'(brs_pkg::MAX_ELEMENTS));

   assign l_m1 = req.left_index - brs_pkg::IDX_W'(1);
   assign r_m1 = req.right_index - brs_pkg::IDX_W'(1);

   // classified command
   always_comb begin
      cmd.op    = brs_pkg::op_type'(req.opcode);
      cmd.bad   = bad;
      cmd.lo    = l_m1[brs_pkg::ADDR_W-1:0];
      cmd.hi    = r_m1[brs_pkg::ADDR_W-1:0];
      cmd.delta = req.delta;
   end

endmodule

// ===== rtl/brs_queue.sv =====
`include "assert_macros.svh"

module brs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  brs_pkg::cmd_type     push_cmd,
   input  logic                 pop,
   output brs_pkg::cmd_type     head,
   output brs_pkg::q_stat_type  q_stat
);

   brs_pkg::cmd_type             slot_ff [brs_pkg::QUEUE_DEPTH];
   logic [brs_pkg::QPTR_W-1:0]   wr_ff, wr_in;
   logic [brs_pkg::QPTR_W-1:0]   rd_ff, rd_in;
   logic [brs_pkg::QPTR_W:0]     cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wr_in  = push ? wr_ff + brs_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + brs_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (brs_pkg::QPTR_W+1)'(push) - (brs_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   assign head         = slot_ff[rd_ff];
   assign q_stat.full  = (cnt_ff == (brs_pkg::QPTR_W+1)'(brs_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);

   `BRS_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= (brs_pkg::QPTR_W+1)'(brs_pkg::QUEUE_DEPTH), "queue count over depth")
   `BRS_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/brs_back.sv =====
`include "assert_macros.svh"

module brs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  brs_pkg::cmd_type     head,
   input  brs_pkg::q_stat_type  q_stat,
   output logic                 pop,
   output logic                 clearing,
   brs_rsp_if.source            rsp
);

   localparam int AW = brs_pkg::ADDR_W;
   localparam int OW = brs_pkg::OFS_W;
   localparam int BW = brs_pkg::BLK_W;
   localparam int CW = brs_pkg::CNT_W;
   localparam int VW = brs_pkg::VAL_W;

   brs_pkg::bk_state_type state_ff, state_in;
   brs_pkg::cmd_type      cmd_ff, cmd_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         end_ff, end_in;
   logic [OW-1:0]         sofs_ff, sofs_in;
   logic                  seg_ff, seg_in;
   logic [BW-1:0]         blk_ff, blk_in;
   logic [VW-1:0]         acc_ff, acc_in;
   logic [VW-1:0]         prod_ff, prod_in;
   logic [VW-1:0]         rd_data_ff;
   logic [AW-1:0]         rd_addr_ff;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]         rsp_total_ff, rsp_total_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic [VW-1:0]         mem [brs_pkg::MAX_ELEMENTS];
   logic [VW-1:0]         sums_ff [brs_pkg::NUM_BLOCKS];
   logic [VW-1:0]         pend_ff [brs_pkg::NUM_BLOCKS];

   logic [BW-1:0]         bl, bh, seg_blk;
   logic                  multi, inner_any, out_free;
   logic [VW-1:0]         delta64, mul_a;
   logic [CW-1:0]         cnt;
   logic [VW+CW-1:0]      mul_full;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [VW-1:0]         mem_wdata;
   logic                  blk_we_sum, blk_we_pend;
   logic [BW-1:0]         blk_waddr;
   logic [VW-1:0]         blk_wdata;

   // command decode
   assign bl        = cmd_ff.lo[AW-1:OW];
   assign bh        = cmd_ff.hi[AW-1:OW];
   assign multi     = (bl != bh);
   assign inner_any = multi && (bh != bl + BW'(1));
   assign seg_blk   = seg_ff ? bh : bl;
   assign delta64   = VW'(cmd_ff.delta);
   assign cnt       = {1'b0, end_ff[OW-1:0]} - {1'b0, sofs_ff} + CW'(1);
   assign mul_a     = (cmd_ff.op == brs_pkg::OP_ADD) ? delta64 : pend_ff[seg_blk];
   assign mul_full  = mul_a * cnt;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brs_pkg::BK_CLEAR: begin
            if (ptr_ff == AW'(brs_pkg::MAX_ELEMENTS - 1)) state_in = brs_pkg::BK_IDLE;
         end
         brs_pkg::BK_IDLE: begin
            if (!q_stat.empty) state_in = brs_pkg::BK_START;
         end
         brs_pkg::BK_START: begin
            state_in = cmd_ff.bad ? brs_pkg::BK_DONE : brs_pkg::BK_WALK;
         end
         brs_pkg::BK_WALK: begin
            if (ptr_ff == end_ff) state_in = brs_pkg::BK_MUL;
         end
         brs_pkg::BK_MUL: begin
            state_in = brs_pkg::BK_ACC;
         end
         brs_pkg::BK_ACC: begin
            if (!seg_ff && multi) state_in = brs_pkg::BK_WALK;
            else if (inner_any) state_in = brs_pkg::BK_INNER;
            else state_in = brs_pkg::BK_DONE;
         end
         brs_pkg::BK_INNER: begin
            if (blk_ff == bh - BW'(1)) state_in = brs_pkg::BK_DONE;
         end
         brs_pkg::BK_DONE: begin
            if (out_free) state_in = brs_pkg::BK_IDLE;
         end
         default: state_in = brs_pkg::BK_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      sofs_in       = sofs_ff;
      seg_in        = seg_ff;
      blk_in        = blk_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rd_vld_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = rd_addr_ff;
      mem_wdata     = rd_data_ff + delta64;
      blk_we_sum    = 1'b0;
      blk_we_pend   = 1'b0;
      blk_waddr     = seg_blk;
      blk_wdata     = sums_ff[seg_blk] + prod_ff;

      // trailing element read from the walk
      if (rd_vld_ff) begin
         if (cmd_ff.op == brs_pkg::OP_ADD) mem_we = 1'b1;
         else acc_in = acc_ff + rd_data_ff;
      end

      unique case (state_ff)
         brs_pkg::BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = '0;
            ptr_in    = ptr_ff + AW'(1);
         end
         brs_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = head;
            end
         end
         brs_pkg::BK_START: begin
            acc_in  = '0;
            seg_in  = 1'b0;
            ptr_in  = cmd_ff.lo;
            sofs_in = cmd_ff.lo[OW-1:0];
            end_in  = multi ? {bl, {OW{1'b1}}} : cmd_ff.hi;
         end
         brs_pkg::BK_WALK: begin
            rd_vld_in = 1'b1;
            ptr_in    = ptr_ff + AW'(1);
         end
         brs_pkg::BK_MUL: begin
            prod_in = mul_full[VW-1:0];
         end
         brs_pkg::BK_ACC: begin
            if (cmd_ff.op == brs_pkg::OP_ADD) blk_we_sum = 1'b1;
            else acc_in = acc_ff + prod_ff;
            seg_in  = 1'b1;
            ptr_in  = {bh, {OW{1'b0}}};
            sofs_in = '0;
            end_in  = cmd_ff.hi;
            blk_in  = bl + BW'(1);
         end
         brs_pkg::BK_INNER: begin
            blk_in = blk_ff + BW'(1);
            if (cmd_ff.op == brs_pkg::OP_ADD) begin
               blk_we_pend = 1'b1;
               blk_waddr   = blk_ff;
               blk_wdata   = pend_ff[blk_ff] + delta64;
            end else begin
               acc_in = acc_ff + sums_ff[blk_ff] + (pend_ff[blk_ff] << OW);
            end
         end
         brs_pkg::BK_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cmd_ff.bad;
               rsp_total_in  = (cmd_ff.op == brs_pkg::OP_SUM && !cmd_ff.bad) ? acc_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brs_pkg::BK_CLEAR;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      end_ff        <= end_in;
      sofs_ff       <= sofs_in;
      seg_ff        <= seg_in;
      blk_ff        <= blk_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   // element memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[ptr_ff];
      rd_addr_ff <= ptr_ff;
   end

   // per-block sums and pending adds
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < brs_pkg::NUM_BLOCKS; i++) begin
            sums_ff[i] <= '0;
            pend_ff[i] <= '0;
         end
      end else begin
         if (blk_we_sum) sums_ff[blk_waddr] <= blk_wdata;
         if (blk_we_pend) pend_ff[blk_waddr] <= blk_wdata;
      end
   end

   assign clearing        = (state_ff == brs_pkg::BK_CLEAR);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.range_total = rsp_total_ff;
   assign rsp.status      = rsp_status_ff;

   `BRS_ASSERT_IMPLIES(a_bad_zero, clock, reset, rsp_valid_ff && rsp_status_ff, rsp_total_ff == '0, "invalid word with nonzero total")
   `BRS_ASSERT_IMPLIES(a_pop_idle, clock, reset, pop, state_ff == brs_pkg::BK_IDLE, "pop outside idle")

endmodule
